/* rtl/esfr_pkg.sv */
`default_nettype none
package esfr_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'h55;
  localparam logic [7:0]  CRC_POLY      = 8'h07;
  localparam logic [16:0] MAX_PAYLOAD_RST = 17'd300;
  localparam int          HDR_LEN       = 5;
  localparam int          HDR_IDX_W     = $clog2(HDR_LEN);
  localparam int          QUEUE_DEPTH   = 2;
  localparam int          QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int          QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [15:0] data_length;
    logic [7:0]  opt_length;
    logic [7:0]  packet_type;
    logic        too_long;
    logic [7:0]  payload_byte;
    logic [16:0] byte_index;
    logic        is_optional;
    logic        last;
    logic        crc_ok;
  } res_t;

  function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/esfr_front.sv */
`default_nettype none
module esfr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     rx_byte_i,
  input  wire logic           cfg_we_i,
  input  wire logic [16:0]    cfg_data_i,
  output logic                push_o,
  output esfr_pkg::res_t      res_o
);
  import esfr_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  hdr_q [HDR_LEN];
  logic [7:0]  hdr_d [HDR_LEN];
  logic [7:0]  nb    [HDR_LEN];
  logic [16:0] cnt_q, cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic [16:0] max_q;

  logic [HDR_IDX_W-1:0] hidx;
  logic [HDR_IDX_W-1:0] pos;
  logic                 found;
  logic [3:0]           src;
  logic [7:0]           hcrc;
  logic [16:0]          hsize;
  logic [15:0]          p_dlen;
  logic [16:0]          p_last_idx;
  logic                 p_is_last;
  logic                 too_long;
  res_t                 res;
  logic                 push;

  always_comb begin
    hidx = (cnt_q >= 17'(HDR_LEN)) ? '0 : cnt_q[HDR_IDX_W-1:0];
    for (int k = 0; k < HDR_LEN; k++) begin
      nb[k] = hdr_q[k];
    end
    nb[hidx] = rx_byte_i;

    hcrc = 8'h00;
    for (int k = 0; k < HDR_LEN - 1; k++) begin
      hcrc = crc8_add(hcrc, nb[k]);
    end
    hsize    = {1'b0, nb[0], nb[1]} + {9'b0, nb[2]} + 17'd1;
    too_long = hsize > max_q;

    found = 1'b0;
    pos   = '0;
    for (int k = HDR_LEN - 1; k >= 0; k--) begin
      if (nb[k] == SYNC_BYTE) begin
        found = 1'b1;
        pos   = HDR_IDX_W'(k);
      end
    end

    p_dlen     = {hdr_q[0], hdr_q[1]};
    p_last_idx = {1'b0, p_dlen} + {9'b0, hdr_q[2]};
    p_is_last  = cnt_q >= p_last_idx;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    src     = '0;
    for (int k = 0; k < HDR_LEN; k++) begin
      hdr_d[k] = hdr_q[k];
    end
    push = 1'b0;
    res  = '0;

    if (accept_i) begin
      case (phase_q)
        PH_HEADER: begin
          for (int k = 0; k < HDR_LEN; k++) begin
            hdr_d[k] = nb[k];
          end
          cnt_d = 17'(hidx) + 17'd1;
          if (hidx == HDR_IDX_W'(HDR_LEN - 1)) begin
            if (hcrc != nb[HDR_LEN-1]) begin
              if (found) begin
                for (int j = 0; j < HDR_LEN - 1; j++) begin
                  src = 4'(j) + 4'(pos) + 4'd1;
                  if (src < 4'(HDR_LEN)) begin
                    hdr_d[j] = nb[src[HDR_IDX_W-1:0]];
                  end
                end
                cnt_d = 17'(HDR_LEN - 1) - 17'(pos);
              end else begin
                cnt_d   = '0;
                phase_d = PH_HUNT;
              end
            end else begin
              push             = 1'b1;
              res.data_length  = {nb[0], nb[1]};
              res.opt_length   = nb[2];
              res.packet_type  = nb[3];
              res.too_long     = too_long;
              cnt_d            = '0;
              crc_d            = 8'h00;
              phase_d          = too_long ? PH_HUNT : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          push             = 1'b1;
          res.kind         = 1'b1;
          res.data_length  = p_dlen;
          res.opt_length   = hdr_q[2];
          res.packet_type  = hdr_q[3];
          res.payload_byte = rx_byte_i;
          res.byte_index   = cnt_q;
          res.is_optional  = !p_is_last && (cnt_q >= {1'b0, p_dlen});
          res.last         = p_is_last;
          res.crc_ok       = p_is_last && (crc_q == rx_byte_i);
          if (p_is_last) begin
            phase_d = PH_HUNT;
            cnt_d   = '0;
          end else begin
            crc_d = crc8_add(crc_q, rx_byte_i);
            cnt_d = cnt_q + 17'd1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == SYNC_BYTE) begin
            phase_d = PH_HEADER;
            cnt_d   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      crc_q   <= '0;
      max_q   <= MAX_PAYLOAD_RST;
      for (int k = 0; k < HDR_LEN; k++) begin
        hdr_q[k] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      for (int k = 0; k < HDR_LEN; k++) begin
        hdr_q[k] <= hdr_d[k];
      end
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  assign push_o = push;
  assign res_o  = res;

endmodule
`default_nettype wire

/* rtl/esfr_queue.sv */
`default_nettype none
module esfr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire esfr_pkg::res_t res_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output esfr_pkg::res_t      res_o
);
  import esfr_pkg::*;

  res_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && !stall_i;
  assign res_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/esp3_serial_frame_receiver.sv */
// Serial frame receiver: one received byte per beat, one beat per cycle while the queue
// has room. The front end hunts for the 0x55 sync byte, checks the header CRC-8
// (rescanning the five stored bytes for a new sync on a mismatch) and emits a header beat,
// then, unless the header is too long, one beat per payload byte with its index, the last
// one carrying the payload CRC result. Results go through a two-entry queue, so an input
// beat is taken every cycle while the queue has room. in_stall_o rises only when the
// queue is full. max_payload_bytes (reset 300) may be rewritten while idle.
`default_nettype none
module esp3_serial_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [16:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [15:0]      data_length_o,
  output logic [7:0]       opt_length_o,
  output logic [7:0]       packet_type_o,
  output logic             too_long_o,
  output logic [7:0]       payload_byte_o,
  output logic [16:0]      byte_index_o,
  output logic             is_optional_o,
  output logic             last_o,
  output logic             crc_ok_o
);
  import esfr_pkg::*;

  logic full, push, accept;
  res_t front_res, q_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  esfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .res_o      (front_res)
  );

  esfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (front_res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (q_res)
  );

  assign kind_o         = q_res.kind;
  assign data_length_o  = q_res.data_length;
  assign opt_length_o   = q_res.opt_length;
  assign packet_type_o  = q_res.packet_type;
  assign too_long_o     = q_res.too_long;
  assign payload_byte_o = q_res.payload_byte;
  assign byte_index_o   = q_res.byte_index;
  assign is_optional_o  = q_res.is_optional;
  assign last_o         = q_res.last;
  assign crc_ok_o       = q_res.crc_ok;

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result queue");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> kind_o && !is_optional_o)
    else $error("last beat not a plain payload byte");

  a_too_long_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> !kind_o && byte_index_o == 17'd0)
    else $error("too_long on a payload beat");

  a_optional_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_optional_o |-> byte_index_o >= {1'b0, data_length_o})
    else $error("optional byte inside data section");

endmodule
`default_nettype wire

/* tb/sv/tb_esp3_serial_frame_receiver.sv */
`default_nettype none
module tb_esp3_serial_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import esfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [16:0] LIMIT_MAX   = 17'd65791;
  localparam logic [16:0] LIMIT_MIN   = 17'd1;

  typedef enum logic [1:0] {HUNT, IN_HDR, IN_BODY} rx_phase_e;

  class frame_tracker;
    rx_phase_e   ph;
    logic [7:0]  hdr[HDR_LEN];
    logic [16:0] cnt;
    logic [7:0]  body_crc;
    logic [16:0] limit;
    res_t        awaited[$];
    int unsigned errors;

    function new();
      ph       = HUNT;
      cnt      = '0;
      body_crc = '0;
      limit    = MAX_PAYLOAD_RST;
      errors   = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    static function logic [7:0] crc8(logic [7:0] c, logic [7:0] d);
      logic [7:0] r;
      r = c ^ d;
      repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
    endfunction

    static function logic [7:0] hdr_crc(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                        logic [7:0] d);
      return crc8(crc8(crc8(crc8(8'h00, a), b), c), d);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function res_t header_fields();
      res_t r;
      r             = '0;
      r.data_length = {hdr[0], hdr[1]};
      r.opt_length  = hdr[2];
      r.packet_type = hdr[3];
      return r;
    endfunction

    function void take_byte(logic [7:0] b);
      res_t        r;
      logic [16:0] size;
      int          pos;
      size = 17'({hdr[0], hdr[1]}) + 17'(hdr[2]) + 17'd1;
      case (ph)
        IN_HDR: begin
          if (cnt >= HDR_LEN) cnt = '0;
          hdr[cnt] = b;
          cnt++;
          if (cnt < HDR_LEN) return;
          if (hdr_crc(hdr[0], hdr[1], hdr[2], hdr[3]) != hdr[4]) begin
            pos = HDR_LEN;
            for (int k = HDR_LEN - 1; k >= 0; k--) if (hdr[k] == SYNC_BYTE) pos = k;
            if (pos < HDR_LEN) begin
              for (int k = 0; k < HDR_LEN - 1 - pos; k++) hdr[k] = hdr[pos + 1 + k];
              cnt = 17'(HDR_LEN - 1 - pos);
            end else begin
              cnt = '0;
              ph  = HUNT;
            end
            return;
          end
          r        = header_fields();
          size     = 17'({hdr[0], hdr[1]}) + 17'(hdr[2]) + 17'd1;
          cnt      = '0;
          body_crc = '0;
          if (size > limit) begin
            r.too_long = 1'b1;
            ph         = HUNT;
          end else begin
            ph = IN_BODY;
          end
          awaited.push_back(r);
        end
        IN_BODY: begin
          r              = header_fields();
          r.kind         = 1'b1;
          r.payload_byte = b;
          r.byte_index   = cnt;
          if (cnt >= size - 17'd1) begin
            r.last   = 1'b1;
            r.crc_ok = (body_crc == b);
            ph       = HUNT;
            cnt      = '0;
          end else begin
            r.is_optional = (cnt >= 17'({hdr[0], hdr[1]}));
            body_crc      = crc8(body_crc, b);
            cnt++;
          end
          awaited.push_back(r);
        end
        default: begin
          ph = HUNT;
          if (b == SYNC_BYTE) begin
            ph  = IN_HDR;
            cnt = '0;
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing expected, kind %0h index %0h", $time,
                 got.kind, got.byte_index);
        errors++;
        return;
      end
      want = awaited.pop_front();
      cmp("kind", want.kind, got.kind);
      cmp("data_length", want.data_length, got.data_length);
      cmp("opt_length", want.opt_length, got.opt_length);
      cmp("packet_type", want.packet_type, got.packet_type);
      cmp("too_long", want.too_long, got.too_long);
      cmp("payload_byte", want.payload_byte, got.payload_byte);
      cmp("byte_index", want.byte_index, got.byte_index);
      cmp("is_optional", want.is_optional, got.is_optional);
      cmp("last", want.last, got.last);
      cmp("crc_ok", want.crc_ok, got.crc_ok);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        cfg_valid = 1'b0;
  logic [16:0] cfg_data  = '0;
  logic        out_stall = 1'b0;
  logic        in_stall_o, cfg_ready_o, out_valid_o;
  logic        kind_o, too_long_o, is_optional_o, last_o, crc_ok_o;
  logic [15:0] data_length_o;
  logic [7:0]  opt_length_o, packet_type_o, payload_byte_o;
  logic [16:0] byte_index_o;

  frame_tracker tracker = new();
  res_t         seen;
  bit           idle_on = 1'b1;
  int unsigned  items   = 0;
  int unsigned  cycles  = 0;

  esp3_serial_frame_receiver i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .data_length_o (data_length_o),
    .opt_length_o  (opt_length_o),
    .packet_type_o (packet_type_o),
    .too_long_o    (too_long_o),
    .payload_byte_o(payload_byte_o),
    .byte_index_o  (byte_index_o),
    .is_optional_o (is_optional_o),
    .last_o        (last_o),
    .crc_ok_o      (crc_ok_o)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) tracker.take_byte(rx_byte);
      if (out_valid_o && !out_stall) begin
        seen.kind         = kind_o;
        seen.data_length  = data_length_o;
        seen.opt_length   = opt_length_o;
        seen.packet_type  = packet_type_o;
        seen.too_long     = too_long_o;
        seen.payload_byte = payload_byte_o;
        seen.byte_index   = byte_index_o;
        seen.is_optional  = is_optional_o;
        seen.last         = last_o;
        seen.crc_ok       = crc_ok_o;
        tracker.check_result(seen);
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic send_body(int unsigned size, bit bad_crc);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    for (int unsigned n = 0; n + 1 < size; n++) begin
      b   = 8'($urandom);
      sum = frame_tracker::crc8(sum, b);
      send_byte(b);
    end
    if (bad_crc) sum ^= 8'(1 << $urandom_range(0, 7));
    send_byte(sum);
    items += size;
  endtask

  task automatic send_packet(logic [15:0] dlen, logic [7:0] opt, logic [7:0] ptype,
                             bit bad_hdr, bit bad_crc);
    logic [7:0]  hc;
    logic [16:0] size;
    hc = frame_tracker::hdr_crc(dlen[15:8], dlen[7:0], opt, ptype);
    if (bad_hdr) hc ^= 8'(1 << $urandom_range(0, 7));
    size = 17'(dlen) + 17'(opt) + 17'd1;
    send_byte(SYNC_BYTE);
    send_byte(dlen[15:8]);
    send_byte(dlen[7:0]);
    send_byte(opt);
    send_byte(ptype);
    send_byte(hc);
    items += HDR_LEN + 1;
    if (!bad_hdr && size <= tracker.limit) send_body(size, bad_crc);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic set_limit(logic [16:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid     <= 1'b0;
    tracker.limit  = value;
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned stop;
    logic [15:0] dlen;
    logic [7:0]  opt;
    stop = items + n;
    while (items < stop) begin
      if (tracker.limit <= 17'd300 && $urandom_range(0, 9) == 0) begin
        dlen = 16'($urandom);
      end else begin
        dlen = 16'($urandom_range(0, 12));
      end
      opt = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
        end
        1: send_packet(dlen, opt, 8'($urandom), 1'b1, 1'b0);
        2: send_packet(dlen, opt, 8'($urandom), 1'b0, 1'b1);
        default: send_packet(dlen, opt, 8'($urandom), 1'b0, 1'b0);
      endcase
    end
  endtask

  initial begin
    logic [7:0] t;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default limit, short packets and corner headers
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(16'h0001, 8'h01, 8'h0A, 1'b0, 1'b0);
    send_packet(16'h012C, 8'h00, 8'h01, 1'b0, 1'b0);
    send_packet(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_packet(16'h0000, 8'h00, 8'h00, 1'b0, 1'b1);
    // bad header crc, sync found in the stored bytes, header completes from there
    t = frame_tracker::hdr_crc(SYNC_BYTE, 8'h00, 8'h00, 8'h02) ^ 8'h01;
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(t);
    send_byte(frame_tracker::hdr_crc(8'h00, 8'h00, 8'h02, t));
    send_body(3, 1'b0);

    set_limit(LIMIT_MIN);
    random_traffic(250);
    set_limit(LIMIT_MAX);
    random_traffic(350);
    set_limit(MAX_PAYLOAD_RST);
    random_traffic(150);
    wait_drained();
    random_traffic(150);
    set_limit(17'($urandom_range(2, 24)));
    random_traffic(350);
    set_limit(17'($urandom_range(1, 65791)));
    random_traffic(300);

    // final stretch without idling, a longer packet included
    idle_on = 1'b0;
    set_limit(LIMIT_MAX);
    send_packet(16'h0040, 8'h10, 8'($urandom), 1'b0, 1'b0);
    random_traffic(150);

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
